>>> rtl/core/kpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpsd_pkg;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_KEY     = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic PHASE_ROW = 1'b0;
  localparam logic PHASE_COL = 1'b1;

  localparam logic [3:0]  LINES_IDLE     = 4'hF;
  localparam logic [15:0] RELOAD_DEFAULT = 16'd300;

  typedef struct packed {
    logic        phase;
    logic [3:0]  latched_rows;
    logic [15:0] debounce_count;
  } kpsd_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] key_code;
    logic       drive_rows;
  } kpsd_result_t;

  typedef struct packed {
    logic       found;
    logic [1:0] index;
  } kpsd_line_t;

  // Locate the single low line of an active-low nibble.
  function automatic kpsd_line_t single_low(input logic [3:0] levels);
    kpsd_line_t line;
    line.found = 1'b1;
    line.index = 2'd0;
    case (levels)
      4'hE:    line.index = 2'd0;
      4'hD:    line.index = 2'd1;
      4'hB:    line.index = 2'd2;
      4'h7:    line.index = 2'd3;
      default: line.found = 1'b0;
    endcase
    return line;
  endfunction

  // Key layout by row line and column line.
  function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] key;
    case ({row, col})
      4'b00_00: key = 4'd1;
      4'b00_01: key = 4'd4;
      4'b00_10: key = 4'd7;
      4'b00_11: key = 4'd14;
      4'b01_00: key = 4'd2;
      4'b01_01: key = 4'd5;
      4'b01_10: key = 4'd8;
      4'b01_11: key = 4'd0;
      4'b10_00: key = 4'd3;
      4'b10_01: key = 4'd6;
      4'b10_10: key = 4'd9;
      4'b10_11: key = 4'd15;
      4'b11_00: key = 4'd10;
      4'b11_01: key = 4'd11;
      4'b11_10: key = 4'd12;
      4'b11_11: key = 4'd13;
      default:  key = 4'd0;
    endcase
    return key;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kpsd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module kpsd_step (
  input  wire kpsd_pkg::kpsd_state_t  state,
  input  wire logic [3:0]             rows,
  input  wire logic [3:0]             cols,
  input  wire logic [15:0]            reload,
  output kpsd_pkg::kpsd_state_t       state_next,
  output kpsd_pkg::kpsd_result_t      result
);
  import kpsd_pkg::*;

  kpsd_line_t row_line;
  kpsd_line_t col_line;

  always_comb begin
    row_line   = single_low(state.latched_rows);
    col_line   = single_low(cols);
    state_next = state;
    result.status   = STATUS_NONE;
    result.key_code = 4'd0;
    if (state.phase == PHASE_ROW) begin
      if (rows != LINES_IDLE) begin
        if (state.debounce_count == 16'd0) begin
          state_next.latched_rows = rows;
          state_next.phase        = PHASE_COL;
        end
      end else begin
        state_next.latched_rows = LINES_IDLE;
        if (state.debounce_count != 16'd0) begin
          state_next.debounce_count = state.debounce_count - 16'd1;
        end
      end
    end else begin
      if (row_line.found && col_line.found) begin
        result.status   = STATUS_KEY;
        result.key_code = key_lookup(row_line.index, col_line.index);
      end else begin
        result.status = STATUS_UNKNOWN;
      end
      state_next.debounce_count = reload;
      state_next.latched_rows   = LINES_IDLE;
      state_next.phase          = PHASE_ROW;
    end
    result.drive_rows = state_next.phase;
  end

endmodule

`default_nettype wire

>>> rtl/core/keypad_scan_debounce_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// 4x4 matrix keypad scanner with debounce. Each request is one poll of the eight
// active-low keypad lines and yields exactly one result: status, key code and the
// drive-select for the next poll. One request is taken every clock cycle while in_stall
// is low; a taken request is held in the input register, which feeds the decode and
// state update, which writes the result register. The scan state is updated once per
// request in that single decode stage. The debounce reload register is written
// through the cfg channel, which is always ready.
module keypad_scan_debounce_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  row_levels,
  input  wire logic [3:0]  column_levels,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [3:0]       key_code,
  output logic             drive_rows,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import kpsd_pkg::*;

  logic         hold_valid;
  logic [3:0]   hold_rows;
  logic [3:0]   hold_cols;
  logic [15:0]  reload;
  kpsd_state_t  state;
  kpsd_state_t  state_next;
  kpsd_result_t result;
  logic         advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = hold_valid && !advance;

  kpsd_step u_step (
    .state      (state),
    .rows       (hold_rows),
    .cols       (hold_cols),
    .reload     (reload),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= RELOAD_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      reload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_rows <= row_levels;
      hold_cols <= column_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PHASE_ROW;
      state.latched_rows   <= LINES_IDLE;
      state.debounce_count <= 16'd0;
      out_valid            <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
      if (hold_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      status     <= result.status;
      key_code   <= result.key_code;
      drive_rows <= result.drive_rows;
    end
  end

  a_col_phase_settled: assert property (@(posedge clk) disable iff (rst)
    state.phase == PHASE_COL |-> state.debounce_count == 16'd0)
    else $error("column phase entered while debouncing");

  a_row_phase_idle: assert property (@(posedge clk) disable iff (rst)
    state.phase == PHASE_ROW |-> state.latched_rows == LINES_IDLE)
    else $error("latched rows not cleared in row phase");

  a_drive_rows_no_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_rows |-> status == STATUS_NONE)
    else $error("key reported while entering column phase");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_KEY |-> key_code == 4'd0)
    else $error("key code set without a valid key");

endmodule

`default_nettype wire
